@@ src/jse_pkg.sv @@
package jse_pkg;

  localparam int unsigned CapResetVal = 256;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  localparam logic [7:0] ChrQuote     = 8'h22;
  localparam logic [7:0] ChrBackslash = 8'h5c;
  localparam logic [7:0] ChrU         = 8'h75;
  localparam logic [7:0] ChrZero      = 8'h30;
  localparam logic [7:0] CtrlLimit    = 8'h20;
  localparam logic [3:0] NibbleMask   = 4'hf;

  localparam logic [2:0] RegCapacity = 3'd0;

  typedef enum logic [1:0] {
    KIND_TERM,
    KIND_PLAIN,
    KIND_PAIR,
    KIND_CTRL
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = ChrZero + {4'd0, nib};
    end else begin
      res = 8'h61 + {4'd0, nib - 4'd10};
    end
    return res;
  endfunction

endpackage

@@ src/jse_front.sv @@
module jse_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         source_byte_i,
  input  logic               q_full_i,
  output logic               push_o,
  output jse_pkg::entry_t    push_entry_o
);
  import jse_pkg::*;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    push_entry_o.ch = source_byte_i;
    if (source_byte_i == 8'd0) begin
      push_entry_o.kind = KIND_TERM;
    end else if (source_byte_i == ChrQuote || source_byte_i == ChrBackslash) begin
      push_entry_o.kind = KIND_PAIR;
    end else if (source_byte_i < CtrlLimit) begin
      push_entry_o.kind = KIND_CTRL;
    end else begin
      push_entry_o.kind = KIND_PLAIN;
    end
  end

endmodule

@@ src/jse_queue.sv @@
module jse_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  jse_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output jse_pkg::head_t  head_o
);
  import jse_pkg::*;

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_pop;

  assign full_o       = count_q == QCntW'(QDepth);
  assign head_o.valid = count_q != '0;
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

@@ src/jse_back.sv @@
module jse_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     capacity_i,
  input  jse_pkg::head_t  head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [15:0]     out_index_o,
  output logic            run_last_o,
  output logic            string_done_o,
  output logic            fit_status_o
);
  import jse_pkg::*;

  logic [2:0]  step_q, step_d;
  logic [15:0] wp_q, wp_d;
  logic        ovf_q, ovf_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, byte_d;
  logic [15:0] index_q;
  logic        last_q, last_d;
  logic        done_q, done_d;
  logic        status_q, status_d;

  logic        out_ready;
  logic        emit;
  logic [16:0] wp_inc;
  logic        fits, next_fits, last_step;
  logic [7:0]  seq_byte;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign wp_inc    = {1'b0, wp_q} + 17'd1;
  assign fits      = wp_inc < {1'b0, capacity_i};
  assign next_fits = (wp_inc + 17'd1) < {1'b0, capacity_i};

  always_comb begin
    last_step = 1'b0;
    seq_byte  = head_i.entry.ch;
    case (head_i.entry.kind)
      KIND_PLAIN: begin
        last_step = 1'b1;
      end
      KIND_PAIR: begin
        last_step = step_q == 3'd1;
        if (step_q == 3'd0) begin
          seq_byte = ChrBackslash;
        end
      end
      KIND_CTRL: begin
        last_step = step_q == 3'd5;
        case (step_q)
          3'd0:    seq_byte = ChrBackslash;
          3'd1:    seq_byte = ChrU;
          3'd2:    seq_byte = ChrZero;
          3'd3:    seq_byte = ChrZero;
          3'd4:    seq_byte = hex_digit(head_i.entry.ch[7:4] & NibbleMask);
          default: seq_byte = hex_digit(head_i.entry.ch[3:0] & NibbleMask);
        endcase
      end
      default: begin
        last_step = 1'b1;
        seq_byte  = 8'd0;
      end
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    emit     = 1'b0;
    step_d   = step_q;
    wp_d     = wp_q;
    ovf_d    = ovf_q;
    byte_d   = seq_byte;
    last_d   = 1'b0;
    done_d   = 1'b0;
    status_d = 1'b0;
    if (head_i.valid && out_ready) begin
      if (head_i.entry.kind == KIND_TERM) begin
        emit     = 1'b1;
        byte_d   = 8'd0;
        last_d   = 1'b1;
        done_d   = 1'b1;
        status_d = ovf_q || (wp_inc > {1'b0, capacity_i});
        wp_d     = '0;
        ovf_d    = 1'b0;
        pop_o    = 1'b1;
        step_d   = '0;
      end else if (ovf_q) begin
        pop_o  = 1'b1;
        step_d = '0;
      end else if (!fits) begin
        ovf_d  = 1'b1;
        pop_o  = 1'b1;
        step_d = '0;
      end else begin
        emit   = 1'b1;
        wp_d   = wp_inc[15:0];
        last_d = last_step || !next_fits;
        if (last_step || !next_fits) begin
          pop_o  = 1'b1;
          step_d = '0;
          if (!last_step) begin
            ovf_d = 1'b1;
          end
        end else begin
          step_d = step_q + 3'd1;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      wp_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      wp_q        <= wp_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q   <= byte_d;
      index_q  <= wp_q;
      last_q   <= last_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign out_index_o   = index_q;
  assign run_last_o    = last_q;
  assign string_done_o = done_q;
  assign fit_status_o  = status_q;

endmodule

@@ src/json_string_escaper_unit.sv @@
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o   source_byte_i
// out       output     out_valid_o / out_stall_i out_byte_o, out_index_o, run_last_o,
//                                                string_done_o, fit_status_o
// cfg       input      APB psel/penable/pwrite   paddr, pwdata, prdata (capacity at 0x0)
//
// In the expander a plain source byte gives one output byte, a quote or backslash two,
// a control byte six, the terminator one and a discarded byte none. Each output byte is
// registered after the queue; one leaves per cycle while out_stall_i is low.
// Reset clears the queue, position and overflow flag; capacity returns to 256.
// A 4-entry queue lets input keep flowing while output is stalled or expanding.
module json_string_escaper_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  source_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [15:0] out_index_o,
  output logic        run_last_o,
  output logic        string_done_o,
  output logic        fit_status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import jse_pkg::*;

  logic [15:0] cap_q, cap_d;
  logic        cfg_wr;
  logic        q_full, push, pop;
  entry_t      push_entry;
  head_t       head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cap_d = cap_q;
    if (cfg_wr && ({paddr[2], 2'b00} == RegCapacity)) begin
      cap_d = pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if ({paddr[2], 2'b00} == RegCapacity) begin
      prdata = {16'd0, cap_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 16'(CapResetVal);
    end else begin
      cap_q <= cap_d;
    end
  end

  jse_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .source_byte_i (source_byte_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_entry_o  (push_entry)
  );

  jse_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_o       (head)
  );

  jse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .capacity_i    (cap_q),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .out_index_o   (out_index_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o),
    .fit_status_o  (fit_status_o)
  );

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_done_o |-> run_last_o && (out_byte_o == 8'd0))
    else $error("terminator without last mark or with nonzero byte");

  a_status_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !string_done_o |-> !fit_status_o)
    else $error("status set on ordinary byte");

  a_index_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !string_done_o |-> out_index_o != 16'hffff)
    else $error("ordinary byte at the last index");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("push into full queue");

endmodule
